[hdl/drot_pkg.sv]
package drot_pkg;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_CLAIM    = 3'd1,
    OP_RELEASE  = 3'd2,
    OP_REVOKE   = 3'd3,
    OP_CHECK    = 3'd4,
    OP_FIND     = 3'd5
  } op_e;

  localparam logic [2:0] TYPE_MMIO   = 3'd1;
  localparam logic [2:0] TYPE_IOPORT = 3'd2;
  localparam logic [2:0] TYPE_IRQ    = 3'd3;
  localparam logic [2:0] TYPE_MSI    = 3'd4;
  localparam logic [2:0] TYPE_DMA    = 3'd5;

  localparam logic [3:0] R_INSPECT = 4'd1;
  localparam logic [3:0] R_MAP     = 4'd2;
  localparam logic [3:0] R_SIGNAL  = 4'd4;
  localparam logic [3:0] R_DMA     = 4'd8;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  res_type;
    logic [63:0] device_id;
    logic [63:0] base;
    logic [63:0] length;
    logic [3:0]  rights;
    logic [63:0] res_id;
    logic [63:0] process_id;
    logic [63:0] assigned_device;
    logic        is_driver;
    logic [2:0]  caps;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] new_id;
    logic [2:0]  found_type;
    logic [63:0] found_base;
    logic [63:0] found_length;
    logic [3:0]  found_rights;
    logic [63:0] found_device;
    logic [63:0] found_owner;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, clear scan index
    logic step;      // read slot at index
    logic eval;      // evaluate read data
    logic advance;   // increment index
    logic finish;    // form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // index at final slot
    logic done;      // scan may stop early
  } sts_t;

  function automatic logic rights_fit(logic [2:0] t, logic [3:0] r);
    logic [3:0] allowed;
    allowed = 4'd0;
    case (t)
      TYPE_MMIO, TYPE_IOPORT: allowed = R_INSPECT | R_MAP;
      TYPE_IRQ, TYPE_MSI:     allowed = R_INSPECT | R_SIGNAL;
      TYPE_DMA:               allowed = R_INSPECT | R_DMA;
      default:                allowed = 4'd0;
    endcase
    return (r != 4'd0) && (allowed != 4'd0) && ((r & ~allowed) == 4'd0);
  endfunction

endpackage

[hdl/device_resource_ownership_table.sv]
// Resource window table with one result item per request item. Every
// operation walks the slot memory one entry at a time (read, then
// evaluate), stopping at the first match where the operation allows it.
// Revoke and unused opcodes always walk the whole table, and so does
// register unless it meets an overlapping window. A new item is taken only
// after the previous result item has been delivered.
module device_resource_ownership_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  drot_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output drot_pkg::rsp_t out_data_o
);

  drot_pkg::cmd_t cmd;
  drot_pkg::sts_t sts;

  drot_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  drot_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

endmodule

[hdl/drot_ctrl.sv]
module drot_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  drot_pkg::sts_t  sts_i,
  output drot_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EVAL = 5'b00100,
    S_DONE = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.step = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.done || sts_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

[hdl/drot_dpath.sv]
module drot_dpath #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  drot_pkg::req_t  req_i,
  input  drot_pkg::cmd_t  cmd_i,
  output drot_pkg::sts_t  sts_o,
  output drot_pkg::rsp_t  rsp_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef struct packed {
    logic [63:0] id;
    logic [2:0]  rtype;
    logic [63:0] base;
    logic [63:0] length;
    logic [3:0]  rights;
    logic [63:0] device;
  } ent_t;

  ent_t        ent_mem [TABLE_ENTRIES];
  logic [63:0] own_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [63:0] next_id_q;

  drot_pkg::req_t req_q;
  drot_pkg::rsp_t rsp_q;
  drot_pkg::rsp_t rsp_d;
  logic [IW-1:0] idx_q;
  ent_t          rd_ent_q;
  logic [63:0]   rd_own_q;
  logic          rd_vld_q;

  // scan results
  logic          hit_q;       // id match found / overlap found
  logic [IW-1:0] hit_idx_q;
  logic          free_q;
  logic [IW-1:0] free_idx_q;
  ent_t          hit_ent_q;
  logic [63:0]   hit_own_q;

  logic [63:0] req_end;
  logic [64:0] req_sum;
  logic [64:0] ent_sum;
  logic        id_m, own_m, rights_m, ovl_m;
  logic        hit_now;

  assign req_sum = {1'b0, req_q.base} + {1'b0, req_q.length};
  assign req_end = req_sum[63:0];
  assign ent_sum = {1'b0, rd_ent_q.base} + {1'b0, rd_ent_q.length};

  assign id_m     = rd_vld_q && (rd_ent_q.id == req_q.res_id);
  assign own_m    = (rd_own_q == req_q.process_id);
  assign rights_m = ((rd_ent_q.rights & req_q.rights) == req_q.rights);
  assign ovl_m    = rd_vld_q && (rd_ent_q.device == req_q.device_id) &&
                    (rd_ent_q.rtype == req_q.res_type) &&
                    (ent_sum[64] || ((req_q.base < ent_sum[63:0]) &&
                                     (rd_ent_q.base < req_end)));

  always_comb begin
    hit_now = 1'b0;
    case (req_q.op)
      drot_pkg::OP_REGISTER: hit_now = ovl_m;
      drot_pkg::OP_CLAIM, drot_pkg::OP_FIND: hit_now = id_m;
      drot_pkg::OP_RELEASE: hit_now = id_m && own_m;
      drot_pkg::OP_CHECK: hit_now = id_m && own_m && rights_m;
      default: hit_now = 1'b0;
    endcase
  end

  assign sts_o.last = (idx_q == IW'(TABLE_ENTRIES - 1));
  assign sts_o.done = hit_now && (req_q.op != drot_pkg::OP_REVOKE);

  // claim gating, computed from the matched entry
  logic claim_ok;
  always_comb begin
    claim_ok = (req_q.assigned_device != 64'd0) && req_q.is_driver &&
               req_q.caps[0] && (req_q.rights != 4'd0) && hit_q &&
               (hit_ent_q.device == req_q.assigned_device) &&
               (hit_own_q == 64'd0) &&
               ((req_q.rights & ~hit_ent_q.rights) == 4'd0);
    if ((hit_ent_q.rtype == drot_pkg::TYPE_IRQ || hit_ent_q.rtype == drot_pkg::TYPE_MSI)
        && !req_q.caps[1]) claim_ok = 1'b0;
    if (hit_ent_q.rtype == drot_pkg::TYPE_DMA && !req_q.caps[2]) claim_ok = 1'b0;
  end

  logic reg_pre;
  assign reg_pre = (req_q.res_type != 3'd0) && (req_q.device_id != 64'd0) &&
                   (req_q.length != 64'd0) &&
                   drot_pkg::rights_fit(req_q.res_type, req_q.rights) &&
                   !req_sum[64] && (req_end > req_q.base);

  logic [63:0] gid;
  assign gid = (next_id_q == 64'd0) ? 64'd1 : next_id_q;

  logic reg_ok;
  assign reg_ok = reg_pre && !hit_q && free_q;

  always_comb begin
    rsp_d = '0;
    case (req_q.op)
      drot_pkg::OP_REGISTER: begin
        if (reg_ok) begin
          rsp_d.ok     = 1'b1;
          rsp_d.new_id = gid;
        end
      end
      drot_pkg::OP_CLAIM: rsp_d.ok = claim_ok;
      drot_pkg::OP_RELEASE: rsp_d.ok = hit_q;
      drot_pkg::OP_REVOKE: rsp_d.ok = 1'b1;
      drot_pkg::OP_CHECK: rsp_d.ok = hit_q;
      drot_pkg::OP_FIND: begin
        if (hit_q && req_q.res_id != 64'd0) begin
          rsp_d.ok           = 1'b1;
          rsp_d.found_type   = hit_ent_q.rtype;
          rsp_d.found_base   = hit_ent_q.base;
          rsp_d.found_length = hit_ent_q.length;
          rsp_d.found_rights = hit_ent_q.rights;
          rsp_d.found_device = hit_ent_q.device;
          rsp_d.found_owner  = hit_own_q;
        end
      end
      default: rsp_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.step) begin
      rd_ent_q <= ent_mem[idx_q];
      rd_own_q <= own_mem[idx_q];
    end
    if (cmd_i.eval) begin
      if (req_q.op == drot_pkg::OP_REVOKE && rd_vld_q &&
          req_q.process_id != 64'd0 && own_m)
        own_mem[idx_q] <= 64'd0;
      if (hit_now && !hit_q) begin
        hit_idx_q <= idx_q;
        hit_ent_q <= rd_ent_q;
        hit_own_q <= rd_own_q;
      end
      if (!rd_vld_q && !free_q) free_idx_q <= idx_q;
    end
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
      if (req_q.op == drot_pkg::OP_REGISTER && reg_ok) begin
        ent_mem[free_idx_q] <= '{id: gid, rtype: req_q.res_type, base: req_q.base,
                                 length: req_q.length, rights: req_q.rights,
                                 device: req_q.device_id};
        own_mem[free_idx_q] <= 64'd0;
      end
      if (req_q.op == drot_pkg::OP_CLAIM && claim_ok)
        own_mem[hit_idx_q] <= req_q.process_id;
      if (req_q.op == drot_pkg::OP_RELEASE && hit_q)
        own_mem[hit_idx_q] <= 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      next_id_q <= 64'd1;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (cmd_i.step) rd_vld_q <= valid_q[idx_q];
      if (cmd_i.advance) idx_q <= idx_q + IW'(1);
      if (cmd_i.eval) begin
        if (hit_now) hit_q <= 1'b1;
        if (!rd_vld_q) free_q <= 1'b1;
      end
      if (cmd_i.finish && req_q.op == drot_pkg::OP_REGISTER && reg_ok) begin
        valid_q[free_idx_q] <= 1'b1;
        next_id_q <= gid + 64'd1;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

[hdl/drot_checker.sv]
module drot_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input drot_pkg::rsp_t out_data_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("took two items");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped");

  a_newid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.new_id == 64'd0)
    else $error("id on failure");

endmodule

bind device_resource_ownership_table drot_checker u_chk (.*);

[tb/device_resource_ownership_table_tb.sv]
module device_resource_ownership_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int N_RANDOM = 800;

  typedef struct {
    drot_pkg::req_t req;
    bit             typed;
    logic           ok;
    logic [63:0]    new_id;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  drot_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  drot_pkg::rsp_t out_data_o;

  // own copy of the window table
  logic        win_valid [SLOTS];
  logic [63:0] win_id    [SLOTS];
  logic [2:0]  win_type  [SLOTS];
  logic [63:0] win_base  [SLOTS];
  logic [63:0] win_len   [SLOTS];
  logic [3:0]  win_rights[SLOTS];
  logic [63:0] win_dev   [SLOTS];
  logic [63:0] win_owner [SLOTS];
  logic [63:0] id_next;

  drot_pkg::rsp_t pending_rsp[$];
  int   errors = 0;
  bit   long_hold = 1'b0;

  device_resource_ownership_table uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [3:0] legal_rights(logic [2:0] t);
    case (t)
      drot_pkg::TYPE_MMIO, drot_pkg::TYPE_IOPORT: return drot_pkg::R_INSPECT | drot_pkg::R_MAP;
      drot_pkg::TYPE_IRQ, drot_pkg::TYPE_MSI: return drot_pkg::R_INSPECT | drot_pkg::R_SIGNAL;
      drot_pkg::TYPE_DMA: return drot_pkg::R_INSPECT | drot_pkg::R_DMA;
      default: return 4'd0;
    endcase
  endfunction

  function automatic int slot_of(logic [63:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (win_valid[i] && win_id[i] == id) return i;
    end
    return -1;
  endfunction

  // updates the table copy and returns the result item the block must give
  function automatic drot_pkg::rsp_t apply_op(drot_pkg::req_t q);
    drot_pkg::rsp_t p;
    logic [64:0] span;
    logic [63:0] id;
    logic [3:0] mask;
    bit hit;
    int s;
    p = '0;
    case (q.op)
      drot_pkg::OP_REGISTER: begin
        mask = legal_rights(q.res_type);
        span = {1'b0, q.base} + {1'b0, q.length};
        if (mask != 0 && q.rights != 0 && (q.rights & ~mask) == 0 && q.device_id != 0 &&
            q.length != 0 && !span[64]) begin
          hit = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (win_valid[i] && win_dev[i] == q.device_id && win_type[i] == q.res_type &&
                q.base < win_base[i] + win_len[i] && win_base[i] < span[63:0])
              hit = 1'b1;
          end
          if (!hit) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!win_valid[i]) begin
                id = id_next;
                id_next++;
                if (id == 0) begin
                  id = id_next;
                  id_next++;
                end
                win_valid[i] = 1'b1;
                win_id[i] = id;
                win_type[i] = q.res_type;
                win_base[i] = q.base;
                win_len[i] = q.length;
                win_rights[i] = q.rights;
                win_dev[i] = q.device_id;
                win_owner[i] = '0;
                p.ok = 1'b1;
                p.new_id = id;
                break;
              end
            end
          end
        end
      end
      drot_pkg::OP_CLAIM: begin
        if (q.assigned_device != 0 && q.is_driver && q.caps[0] && q.rights != 0) begin
          s = slot_of(q.res_id);
          if (s >= 0 && win_dev[s] == q.assigned_device && win_owner[s] == 0 &&
              (q.rights & ~win_rights[s]) == 0 &&
              !((win_type[s] == drot_pkg::TYPE_IRQ || win_type[s] == drot_pkg::TYPE_MSI) &&
                !q.caps[1]) &&
              !(win_type[s] == drot_pkg::TYPE_DMA && !q.caps[2])) begin
            win_owner[s] = q.process_id;
            p.ok = 1'b1;
          end
        end
      end
      drot_pkg::OP_RELEASE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (win_valid[i] && win_id[i] == q.res_id && win_owner[i] == q.process_id) begin
            win_owner[i] = '0;
            p.ok = 1'b1;
            break;
          end
        end
      end
      drot_pkg::OP_REVOKE: begin
        if (q.process_id != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (win_valid[i] && win_owner[i] == q.process_id) win_owner[i] = '0;
          end
        end
        p.ok = 1'b1;
      end
      drot_pkg::OP_CHECK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (win_valid[i] && win_id[i] == q.res_id && win_owner[i] == q.process_id &&
              (win_rights[i] & q.rights) == q.rights) begin
            p.ok = 1'b1;
            break;
          end
        end
      end
      drot_pkg::OP_FIND: begin
        s = (q.res_id == 0) ? -1 : slot_of(q.res_id);
        if (s >= 0) begin
          p.ok = 1'b1;
          p.found_type = win_type[s];
          p.found_base = win_base[s];
          p.found_length = win_len[s];
          p.found_rights = win_rights[s];
          p.found_device = win_dev[s];
          p.found_owner = win_owner[s];
        end
      end
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic drot_pkg::req_t mk(logic [2:0] op, logic [2:0] t, logic [63:0] dev,
                                        logic [63:0] base, logic [63:0] len,
                                        logic [3:0] rights, logic [63:0] id,
                                        logic [63:0] pid, logic [63:0] asg,
                                        logic drv, logic [2:0] caps);
    drot_pkg::req_t q;
    q.op = op;
    q.res_type = t;
    q.device_id = dev;
    q.base = base;
    q.length = len;
    q.rights = rights;
    q.res_id = id;
    q.process_id = pid;
    q.assigned_device = asg;
    q.is_driver = drv;
    q.caps = caps;
    return q;
  endfunction

  function automatic drot_pkg::req_t rand_req();
    drot_pkg::req_t q;
    logic [479:0] bits;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      for (int k = 0; k < 15; k++) bits[k*32 +: 32] = $urandom;
      q = drot_pkg::req_t'(bits[$bits(drot_pkg::req_t)-1:0]);
      return q;
    end
    q.op = (pick < 45) ? drot_pkg::OP_REGISTER : 3'($urandom_range(1, 5));
    if (pick > 97) q.op = 3'($urandom_range(6, 7));
    q.res_type = 3'($urandom_range(1, 5));
    q.device_id = 64'($urandom_range(1, 4));
    q.base = 64'($urandom_range(0, 15)) << 12;
    q.length = 64'($urandom_range(1, 3)) << 12;
    q.rights = legal_rights(q.res_type) & 4'($urandom_range(1, 15));
    if (q.op != drot_pkg::OP_REGISTER)
      q.rights = 4'($urandom_range(0, 15)) & 4'($urandom_range(0, 15));
    q.res_id = 64'($urandom_range(0, 32'(id_next) + 1));
    q.process_id = 64'($urandom_range(0, 4));
    q.assigned_device = ($urandom_range(0, 9) == 0) ? '0 : 64'($urandom_range(1, 4));
    q.is_driver = ($urandom_range(0, 7) != 0);
    q.caps = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b111;
    return q;
  endfunction

  task automatic send_item(drot_pkg::req_t q, bit typed, drot_pkg::rsp_t fixed);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i <= q;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_rsp.push_back(typed ? fixed : apply_op(q));
    if (typed) void'(apply_op(q));
    gap = $urandom_range(0, 9);
    gap = (gap < 5) ? 0 : (gap < 9) ? $urandom_range(1, 4) : $urandom_range(20, 100);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 9) < 6) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                             : $urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    drot_pkg::rsp_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $error("result item with none expected");
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_data_o.ok !== want.ok) begin
          $error("ok exp %0h got %0h", want.ok, out_data_o.ok);
          errors++;
        end
        if (out_data_o.new_id !== want.new_id) begin
          $error("new_id exp %0h got %0h", want.new_id, out_data_o.new_id);
          errors++;
        end
        if (out_data_o.found_type !== want.found_type) begin
          $error("found_type exp %0h got %0h", want.found_type, out_data_o.found_type);
          errors++;
        end
        if (out_data_o.found_base !== want.found_base) begin
          $error("found_base exp %0h got %0h", want.found_base, out_data_o.found_base);
          errors++;
        end
        if (out_data_o.found_length !== want.found_length) begin
          $error("found_length exp %0h got %0h", want.found_length, out_data_o.found_length);
          errors++;
        end
        if (out_data_o.found_rights !== want.found_rights) begin
          $error("found_rights exp %0h got %0h", want.found_rights, out_data_o.found_rights);
          errors++;
        end
        if (out_data_o.found_device !== want.found_device) begin
          $error("found_device exp %0h got %0h", want.found_device, out_data_o.found_device);
          errors++;
        end
        if (out_data_o.found_owner !== want.found_owner) begin
          $error("found_owner exp %0h got %0h", want.found_owner, out_data_o.found_owner);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    drot_pkg::rsp_t fixed;
    logic [63:0] ones;
    ones = '1;
    for (int i = 0; i < SLOTS; i++) begin
      win_valid[i] = 1'b0;
      win_id[i] = '0;
      win_type[i] = '0;
      win_base[i] = '0;
      win_len[i] = '0;
      win_rights[i] = '0;
      win_dev[i] = '0;
      win_owner[i] = '0;
    end
    id_next = 64'd1;

    rows.push_back('{mk(drot_pkg::OP_FIND, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_MMIO, 1, 0, 'h1000, 3,
                        0, 0, 0, 0, 0), 1, 1, 1});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_MMIO, 1, 'h8000, 0, 3,
                        0, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, 0, 1, 'h8000, 'h10, 1, 0, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_MMIO, 0, 'h8000, 'h10, 1,
                        0, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_IOPORT, 1, ones, 1, 1,
                        0, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_IRQ, ones, 0, ones, 5,
                        0, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_MMIO, 1, 'h800, 'h1000, 1,
                        0, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_MMIO, 1, 'h1000, 'h1000, 1,
                        0, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_DMA, 5, 0, 'h10, drot_pkg::R_MAP,
                        0, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_MSI, 5, 0, 'h10, 0,
                        0, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REGISTER, drot_pkg::TYPE_DMA, 5, 0, 'h10, 9,
                        0, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_CLAIM, 0, 0, 0, 0, 3, 1, 7, 1, 1, 1), 0, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_CLAIM, 0, 0, 0, 0, 1, 1, 8, 1, 1, 7), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_CLAIM, 0, 0, 0, 0, 1, 2, 9, ones, 1, 1), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_CLAIM, 0, 0, 0, 0, 9, 4, ones, 5, 1, 7), 0, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_CHECK, 0, 0, 0, 0, 3, 1, 7, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_FIND, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_RELEASE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_REVOKE, 0, 0, 0, 0, 0, 0, 7, 0, 0, 0), 1, 1, 0});
    rows.push_back('{mk(drot_pkg::OP_REVOKE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0});
    rows.push_back('{mk(3'd6, 7, ones, ones, ones, 15, ones, ones, ones, 1, 7), 1, 0, 0});
    rows.push_back('{mk(3'd7, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0});
    rows.push_back('{mk(drot_pkg::OP_FIND, 0, 0, 0, 0, 0, 4, 0, 0, 0, 0), 0, 0, 0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      fixed = '0;
      fixed.ok = rows[i].ok;
      fixed.new_id = rows[i].new_id;
      send_item(rows[i].req, rows[i].typed, fixed);
    end

    long_hold = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(posedge clk_i);
      end
      send_item(rand_req(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    wait (pending_rsp.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
